/* sv/cfb_pkg.sv */
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and helpers for the checksum frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

   localparam int MAX_PAYLOAD_BYTES = 8190;
   localparam int QUEUE_DEPTH = 2;

   localparam int LEN_WIDTH = 16;
   localparam int SUM_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [CSR_ADDR_WIDTH-3:0] REG_REMOTE_ADDRESS = '0;

   localparam logic [7:0] SYNC_BYTE = 8'h5A;
   localparam logic [7:0] ODD_FLAG = 8'h80;
   localparam logic [7:0] PAD_BYTE = 8'h00;
   localparam logic [SUM_WIDTH-1:0] SUM_AFTER_HEADER = 16'hFFFF;

   localparam int SLOT_COUNT = 10;
   localparam int SLOT_WIDTH = 4;
   localparam logic [SLOT_WIDTH-1:0] SLOT_SYNC = 4'd0;
   localparam logic [SLOT_WIDTH-1:0] SLOT_ADDR = 4'd1;
   localparam logic [SLOT_WIDTH-1:0] SLOT_SIZE_LO = 4'd2;
   localparam logic [SLOT_WIDTH-1:0] SLOT_SIZE_HI = 4'd3;
   localparam logic [SLOT_WIDTH-1:0] SLOT_HCK_HI = 4'd4;
   localparam logic [SLOT_WIDTH-1:0] SLOT_HCK_LO = 4'd5;
   localparam logic [SLOT_WIDTH-1:0] SLOT_PAYLOAD = 4'd6;
   localparam logic [SLOT_WIDTH-1:0] SLOT_PAD = 4'd7;
   localparam logic [SLOT_WIDTH-1:0] SLOT_CK_HI = 4'd8;
   localparam logic [SLOT_WIDTH-1:0] SLOT_CK_LO = 4'd9;

   typedef struct packed {
      logic [SLOT_COUNT-1:0] mask;
      logic [7:0]            addr;
      logic [7:0]            size_lo;
      logic [7:0]            size_hi;
      logic [SUM_WIDTH-1:0]  hck;
      logic [7:0]            pbyte;
      logic [SUM_WIDTH-1:0]  ck;
   } cmd_type;

   function automatic logic [SUM_WIDTH-1:0] oc_add(input logic [SUM_WIDTH-1:0] a,
                                                   input logic [SUM_WIDTH-1:0] b);
      logic [SUM_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_WIDTH-1:0] + {{(SUM_WIDTH-1){1'b0}}, s[SUM_WIDTH]};
   endfunction

endpackage

/* sv/cfb_front.sv */
// ----------------------------------------------------------------------------
// cfb_front
// Accepts input transactions, tracks frame position and checksums, and builds
// one emission command per transaction.
// ----------------------------------------------------------------------------
module cfb_front #(
   parameter int MAX_PAYLOAD_BYTES = cfb_pkg::MAX_PAYLOAD_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       payload_byte,
   input  logic [12:0]      frame_bytes,
   input  logic [7:0]       remote_address,
   input  logic             q_full,
   output logic             q_push,
   output cfb_pkg::cmd_type q_cmd
);

   localparam int CW = $clog2(MAX_PAYLOAD_BYTES + 1);
   localparam logic [cfb_pkg::LEN_WIDTH-1:0] MAX_LEN =
      cfb_pkg::LEN_WIDTH'(MAX_PAYLOAD_BYTES);

   logic [CW-1:0]                    rem_ff, rem_in;
   logic [cfb_pkg::SUM_WIDTH-1:0]    sum_ff, sum_in;
   logic                             odd_ff, odd_in;

   logic                             accept, first, zero, odd, last, pad;
   logic                             base_odd;
   logic [cfb_pkg::LEN_WIDTH-1:0]    len_ext, len_sat;
   logic [cfb_pkg::LEN_WIDTH:0]      len_round;
   logic [cfb_pkg::LEN_WIDTH-1:0]    size16;
   logic [7:0]                       size_lo, size_hi;
   logic [cfb_pkg::SUM_WIDTH-1:0]    hsum, base_sum, addend;

   assign req_ready = !q_full;
   assign accept = req_valid && req_ready;
   assign q_push = accept;

   always_comb begin
      first = (rem_ff == '0);
      len_ext = {{(cfb_pkg::LEN_WIDTH-13){1'b0}}, frame_bytes};
      len_sat = (len_ext > MAX_LEN) ? MAX_LEN : len_ext;
      odd = len_sat[0];
      len_round = {1'b0, len_sat} + {{cfb_pkg::LEN_WIDTH{1'b0}}, odd};
      size16 = len_round[cfb_pkg::LEN_WIDTH:1];
      size_lo = size16[7:0];
      size_hi = size16[15:8] | (odd ? cfb_pkg::ODD_FLAG : 8'h00);
      hsum = cfb_pkg::oc_add({cfb_pkg::SYNC_BYTE, remote_address}, {size_lo, size_hi});
      zero = first && (len_sat == '0);

      base_sum = first ? cfb_pkg::SUM_AFTER_HEADER : sum_ff;
      base_odd = first ? 1'b0 : odd_ff;
      addend = base_odd ? {8'h00, payload_byte} : {payload_byte, 8'h00};
      sum_in = zero ? base_sum : cfb_pkg::oc_add(base_sum, addend);
      odd_in = zero ? 1'b0 : !base_odd;

      if (first) begin
         rem_in = zero ? '0 : (len_sat[CW-1:0] - CW'(1));
      end else begin
         rem_in = rem_ff - CW'(1);
      end
      last = (rem_in == '0);
      pad = last && odd_in;

      q_cmd.mask = '0;
      q_cmd.mask[cfb_pkg::SLOT_SYNC] = first;
      q_cmd.mask[cfb_pkg::SLOT_ADDR] = first;
      q_cmd.mask[cfb_pkg::SLOT_SIZE_LO] = first;
      q_cmd.mask[cfb_pkg::SLOT_SIZE_HI] = first;
      q_cmd.mask[cfb_pkg::SLOT_HCK_HI] = first;
      q_cmd.mask[cfb_pkg::SLOT_HCK_LO] = first;
      q_cmd.mask[cfb_pkg::SLOT_PAYLOAD] = !zero;
      q_cmd.mask[cfb_pkg::SLOT_PAD] = pad;
      q_cmd.mask[cfb_pkg::SLOT_CK_HI] = last;
      q_cmd.mask[cfb_pkg::SLOT_CK_LO] = last;
      q_cmd.addr = remote_address;
      q_cmd.size_lo = size_lo;
      q_cmd.size_hi = size_hi;
      q_cmd.hck = ~hsum;
      q_cmd.pbyte = payload_byte;
      q_cmd.ck = ~sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         sum_ff <= '0;
         odd_ff <= 1'b0;
      end else if (accept) begin
         rem_ff <= rem_in;
         sum_ff <= sum_in;
         odd_ff <= odd_in;
      end
   end

endmodule

/* sv/cfb_queue.sv */
// ----------------------------------------------------------------------------
// cfb_queue
// Small command queue between the front and back parts of the frame builder.
// ----------------------------------------------------------------------------
module cfb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cfb_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output cfb_pkg::cmd_type head
);

   localparam int PW = (cfb_pkg::QUEUE_DEPTH > 1) ? $clog2(cfb_pkg::QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(cfb_pkg::QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(cfb_pkg::QUEUE_DEPTH - 1);

   cfb_pkg::cmd_type mem_ff [cfb_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [NW-1:0]    count_ff, count_in;

   assign full = (count_ff == NW'(cfb_pkg::QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PW'(1);
      rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PW'(1);
      count_in = count_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_in;
         end
         if (pop) begin
            rd_ff <= rd_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

/* sv/cfb_back.sv */
// ----------------------------------------------------------------------------
// cfb_back
// Walks the byte slots of the queue head and, unless the queue is empty or the
// output stalls, emits one framed byte per cycle through an output register.
// ----------------------------------------------------------------------------
module cfb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  cfb_pkg::cmd_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_byte,
   output logic             rsp_eof,
   output logic             rsp_run_last
);

   localparam logic [cfb_pkg::SLOT_COUNT-1:0] ALL_SLOTS = '1;

   logic [cfb_pkg::SLOT_WIDTH-1:0] step_ff, step_in;
   logic                           valid_ff;
   logic [7:0]                     byte_ff;
   logic                           eof_ff, run_last_ff;

   logic [cfb_pkg::SLOT_COUNT-1:0] pending;
   logic [cfb_pkg::SLOT_WIDTH-1:0] slot;
   logic                           last, load, emit;
   logic [7:0]                     byte_in;

   assign load = !valid_ff || rsp_ready;
   assign emit = q_valid && load;
   assign q_pop = emit && last;
   assign rsp_valid = valid_ff;
   assign rsp_byte = byte_ff;
   assign rsp_eof = eof_ff;
   assign rsp_run_last = run_last_ff;

   always_comb begin
      pending = q_head.mask & (ALL_SLOTS << step_ff);
      slot = '0;
      for (int i = cfb_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (pending[i]) begin
            slot = cfb_pkg::SLOT_WIDTH'(i);
         end
      end
      last = ((pending & (pending - cfb_pkg::SLOT_COUNT'(1))) == '0);
      step_in = last ? '0 : slot + cfb_pkg::SLOT_WIDTH'(1);

      case (slot)
         cfb_pkg::SLOT_SYNC:    byte_in = cfb_pkg::SYNC_BYTE;
         cfb_pkg::SLOT_ADDR:    byte_in = q_head.addr;
         cfb_pkg::SLOT_SIZE_LO: byte_in = q_head.size_lo;
         cfb_pkg::SLOT_SIZE_HI: byte_in = q_head.size_hi;
         cfb_pkg::SLOT_HCK_HI:  byte_in = q_head.hck[15:8];
         cfb_pkg::SLOT_HCK_LO:  byte_in = q_head.hck[7:0];
         cfb_pkg::SLOT_PAYLOAD: byte_in = q_head.pbyte;
         cfb_pkg::SLOT_PAD:     byte_in = cfb_pkg::PAD_BYTE;
         cfb_pkg::SLOT_CK_HI:   byte_in = q_head.ck[15:8];
         cfb_pkg::SLOT_CK_LO:   byte_in = q_head.ck[7:0];
         default:               byte_in = cfb_pkg::PAD_BYTE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            step_ff <= step_in;
         end
         if (load) begin
            valid_ff <= q_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_in;
         eof_ff <= (slot == cfb_pkg::SLOT_CK_LO);
         run_last_ff <= last;
      end
   end

endmodule

/* sv/checksum_frame_builder.sv */
// ----------------------------------------------------------------------------
// checksum_frame_builder
// Frames a payload byte stream with a header and ones' complement checksums.
// ----------------------------------------------------------------------------
// Each input transaction carries one payload byte; the first transaction of a
// frame also carries the payload length, which saturates at MAX_PAYLOAD_BYTES.
// That transaction produces the six header bytes before its payload byte, and
// the transaction with the last payload byte adds a zero pad for odd lengths and
// the two checksum bytes. A zero length produces header and checksum only. The
// output sequencer emits one byte per cycle while the output is not stalled. A
// two-entry command queue lets input transactions keep arriving while header
// and trailer bytes drain, and the input stalls only while that queue is full.
// Output tlast marks the final checksum byte of a frame and tuser marks the
// last byte produced by each input transaction. The remote address register
// sits at byte address 0 and resets to zero.
module checksum_frame_builder #(
   parameter int MAX_PAYLOAD_BYTES = cfb_pkg::MAX_PAYLOAD_BYTES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] payload_byte, [20:8] frame_bytes, [23:21] zero.
   input  logic [23:0]                        req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] frame_byte.
   output logic [7:0]                         rsp_tdata,
   output logic                               rsp_tlast,
   // [0] last_of_run.
   output logic [0:0]                         rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cfb_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [cfb_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [cfb_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);

   logic [7:0]       addr_ff;
   logic             csr_hit, csr_write;
   logic             q_push, q_full, q_pop, q_valid;
   cfb_pkg::cmd_type q_cmd, q_head;

   assign csr_pready = 1'b1;
   assign csr_hit = (csr_paddr[cfb_pkg::CSR_ADDR_WIDTH-1:2] == cfb_pkg::REG_REMOTE_ADDRESS);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? {{(cfb_pkg::CSR_DATA_WIDTH-8){1'b0}}, addr_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else if (csr_write) begin
         addr_ff <= csr_pwdata[7:0];
      end
   end

   cfb_front #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .payload_byte   (req_tdata[7:0]),
      .frame_bytes    (req_tdata[20:8]),
      .remote_address (addr_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (q_cmd)
   );

   cfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   cfb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_byte     (rsp_tdata),
      .rsp_eof      (rsp_tlast),
      .rsp_run_last (rsp_tuser[0])
   );

`ifndef SYNTH
   a_eof_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("End of frame does not close the transaction's output run.");

   a_stall_needs_work: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_valid)
      else $error("Input stalled while the command queue is empty.");

   a_accept_queues: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> q_valid)
      else $error("Accepted transaction did not reach the command queue.");
`endif

endmodule

/* tb/checksum_frame_builder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksum_frame_builder_tb
// Self-checking testbench for the checksum frame builder.
// ----------------------------------------------------------------------------
// Payload bytes go in as input transactions, and every framed output byte is
// compared with a byte-level model of the framer: header, payload, pad and
// ones' complement checksums. A short table of frames comes first, some with
// their closing byte written out by hand. Random frames follow under several
// remote addresses, and the run ends by opening a frame whose length saturates
// at the maximum. Both sides stall at random, except for one stretch that runs
// at full rate.
// ----------------------------------------------------------------------------
module checksum_frame_builder_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [cfb_pkg::CSR_ADDR_WIDTH-1:0] REMOTE_ADDR_BYTE =
      {cfb_pkg::REG_REMOTE_ADDRESS, 2'b00};
   localparam logic [cfb_pkg::CSR_ADDR_WIDTH-1:0] UNUSED_REG_BYTE = {1'b1, 2'b00};

   typedef enum {DO_ITEM, DO_SET_ADDR, DO_SET_UNUSED} dir_action_type;

   typedef struct {
      dir_action_type act;
      logic [7:0]     pb;
      logic [12:0]    flen;
      bit             typed;
      logic [7:0]     tail;
   } dir_row_type;

   typedef struct packed {
      logic [7:0] fbyte;
      logic       eof;
      logic       last_run;
   } out_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [cfb_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [cfb_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [cfb_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic        csr_pready;

   out_byte_type expected_bytes[$];
   logic [7:0]   remote_addr = 8'h00;
   logic [12:0]  bytes_left = '0;
   logic [15:0]  frame_sum = '0;
   logic         low_half = 1'b0;
   logic [7:0]   last_frame_byte = 8'h00;
   int           err_count = 0;
   int           cycle_count = 0;
   int           sent_items = 0;
   bit           no_idle = 1'b0;
   dir_row_type  directed[19];

   checksum_frame_builder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d bytes outstanding", $time, expected_bytes.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= 37);
   end

   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'b0, s[16]};
   endfunction

   task automatic emit_byte(input logic [7:0] fb, input logic eof);
      out_byte_type e;
      e.fbyte = fb;
      e.eof = eof;
      e.last_run = 1'b0;
      expected_bytes.push_back(e);
   endtask

   task automatic take_payload(input logic [7:0] pb);
      emit_byte(pb, 1'b0);
      frame_sum = fold_add(frame_sum, low_half ? {8'h00, pb} : {pb, 8'h00});
      low_half = ~low_half;
   endtask

   task automatic close_frame();
      logic [15:0] ck;
      if (low_half) begin
         emit_byte(cfb_pkg::PAD_BYTE, 1'b0);
         low_half = 1'b0;
      end
      ck = ~frame_sum;
      emit_byte(ck[15:8], 1'b0);
      emit_byte(ck[7:0], 1'b1);
   endtask

   task automatic frame_item(input logic [7:0] pb, input logic [12:0] fb);
      logic [12:0]  flen;
      logic [15:0]  words;
      logic [7:0]   size_hi;
      logic [15:0]  hsum;
      logic [15:0]  hck;
      out_byte_type e;
      if (bytes_left == 0) begin
         flen = (fb > cfb_pkg::MAX_PAYLOAD_BYTES) ? 13'(cfb_pkg::MAX_PAYLOAD_BYTES) : fb;
         words = ({3'b000, flen} + {15'b0, flen[0]}) >> 1;
         size_hi = words[15:8] | (flen[0] ? cfb_pkg::ODD_FLAG : 8'h00);
         hsum = fold_add({cfb_pkg::SYNC_BYTE, remote_addr}, {words[7:0], size_hi});
         hck = ~hsum;
         emit_byte(cfb_pkg::SYNC_BYTE, 1'b0);
         emit_byte(remote_addr, 1'b0);
         emit_byte(words[7:0], 1'b0);
         emit_byte(size_hi, 1'b0);
         emit_byte(hck[15:8], 1'b0);
         emit_byte(hck[7:0], 1'b0);
         frame_sum = fold_add(hsum, hck);
         low_half = 1'b0;
         if (flen == 0) begin
            close_frame();
         end else begin
            take_payload(pb);
            bytes_left = flen - 13'd1;
            if (bytes_left == 0) close_frame();
         end
      end else begin
         take_payload(pb);
         bytes_left = bytes_left - 13'd1;
         if (bytes_left == 0) close_frame();
      end
      e = expected_bytes.pop_back();
      e.last_run = 1'b1;
      expected_bytes.push_back(e);
   endtask

   always @(posedge clock) begin : monitor
      out_byte_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) frame_item(req_tdata[7:0], req_tdata[20:8]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected byte: expected none, got %02h eof %0b last %0b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser[0]);
               err_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (want !== {rsp_tdata, rsp_tlast, rsp_tuser[0]}) begin
                  $display("%0t: byte mismatch: expected %02h eof %0b last %0b, got %02h eof %0b last %0b",
                           $time, want.fbyte, want.eof, want.last_run,
                           rsp_tdata, rsp_tlast, rsp_tuser[0]);
                  err_count++;
               end
            end
            last_frame_byte = rsp_tdata;
         end
      end
   end

   task automatic send_item(input logic [7:0] pb, input logic [12:0] fb);
      while (!no_idle && $urandom_range(0, 99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, fb, pb};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_bytes.size() != 0);
   endtask

   task automatic write_reg(input logic [cfb_pkg::CSR_ADDR_WIDTH-1:0] addr,
                            input logic [cfb_pkg::CSR_DATA_WIDTH-1:0] data);
      drain();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == REMOTE_ADDR_BYTE) remote_addr = data[7:0];
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr <= REMOTE_ADDR_BYTE;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {24'h000000, remote_addr}) begin
         $display("%0t: remote address readback: expected %08h, got %08h",
                  $time, {24'h000000, remote_addr}, csr_prdata);
         err_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_frame(input logic [12:0] flen);
      int count;
      count = (flen > cfb_pkg::MAX_PAYLOAD_BYTES) ? cfb_pkg::MAX_PAYLOAD_BYTES : int'(flen);
      send_item(8'($urandom_range(0, 255)), flen);
      for (int k = 1; k < count; k++) begin
         send_item(8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)));
      end
      sent_items += (count == 0) ? 1 : count;
   endtask

   task automatic random_frames(input int item_goal);
      int pick;
      int stop_at;
      stop_at = sent_items + item_goal;
      while (sent_items < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) send_frame(13'd0);
         else if (pick < 24) send_frame(13'd1);
         else send_frame(13'($urandom_range(2, 12)));
      end
   endtask

   initial begin
      directed = '{
         '{DO_ITEM,       8'hAB, 13'h0000, 1'b1, 8'h00},
         '{DO_ITEM,       8'h00, 13'h0001, 1'b1, 8'h00},
         '{DO_ITEM,       8'hFF, 13'h0001, 1'b1, 8'hFF},
         '{DO_ITEM,       8'h12, 13'h0002, 1'b0, 8'h00},
         '{DO_ITEM,       8'h34, 13'h1FFF, 1'b0, 8'h00},
         '{DO_ITEM,       8'hFF, 13'h0003, 1'b0, 8'h00},
         '{DO_ITEM,       8'hFF, 13'h0000, 1'b0, 8'h00},
         '{DO_ITEM,       8'hFF, 13'h1555, 1'b0, 8'h00},
         '{DO_ITEM,       8'h80, 13'h0004, 1'b0, 8'h00},
         '{DO_ITEM,       8'h01, 13'h0AAA, 1'b0, 8'h00},
         '{DO_ITEM,       8'h7F, 13'h1000, 1'b0, 8'h00},
         '{DO_ITEM,       8'hFE, 13'h0555, 1'b0, 8'h00},
         '{DO_ITEM,       8'h5A, 13'h0001, 1'b1, 8'hFF},
         '{DO_SET_ADDR,   8'hFF, 13'h0000, 1'b0, 8'h00},
         '{DO_SET_UNUSED, 8'hA5, 13'h0000, 1'b0, 8'h00},
         '{DO_ITEM,       8'h00, 13'h0000, 1'b1, 8'h00},
         '{DO_ITEM,       8'hC3, 13'h0002, 1'b0, 8'h00},
         '{DO_ITEM,       8'h3C, 13'h0000, 1'b0, 8'h00},
         '{DO_ITEM,       8'h99, 13'h0001, 1'b1, 8'hFF}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         case (directed[i].act)
            DO_SET_ADDR: begin
               write_reg(REMOTE_ADDR_BYTE, {24'hFFFFFF, directed[i].pb});
            end
            DO_SET_UNUSED: begin
               write_reg(UNUSED_REG_BYTE, {24'hFFFFFF, directed[i].pb});
            end
            default: begin
               send_item(directed[i].pb, directed[i].flen);
               if (directed[i].typed) begin
                  drain();
                  if (last_frame_byte !== directed[i].tail) begin
                     $display("%0t: frame close byte: expected %02h, got %02h",
                              $time, directed[i].tail, last_frame_byte);
                     err_count++;
                  end
               end
            end
         endcase
      end

      sent_items = 0;
      write_reg(REMOTE_ADDR_BYTE, $urandom);
      random_frames(45);

      write_reg(REMOTE_ADDR_BYTE, {24'hFFFFFF, 8'h00});
      no_idle = 1'b1;
      random_frames(40);
      drain();
      no_idle = 1'b0;

      write_reg(UNUSED_REG_BYTE, $urandom);
      write_reg(REMOTE_ADDR_BYTE, $urandom);
      random_frames(35);

      write_reg(REMOTE_ADDR_BYTE, $urandom);
      send_item(8'($urandom_range(0, 255)), 13'h1FFF);
      repeat (3) send_item(8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)));

      drain();
      repeat (20) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
      end
      if (err_count == 0 && expected_bytes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
sv/cfb_pkg.sv
sv/cfb_front.sv
sv/cfb_queue.sv
sv/cfb_back.sv
sv/checksum_frame_builder.sv
tb/checksum_frame_builder_tb.sv
